/* rtl/blbt_pkg.sv */
// Package for the button listener broadcast table.
// Holds command and operation codes, the queued operation type and size constants.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package blbt_pkg;

    localparam int TASK_W        = 8;
    localparam int CMD_W         = 2;
    localparam int SLOT_COUNT    = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_SAMPLE     = 2'd2,
        CMD_IGNORE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_PRESS      = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [TASK_W-1:0] task_id;
    } op_t;

    typedef enum logic {
        BACK_IDLE  = 1'b0,
        BACK_BCAST = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/blbt_if.sv */
// Channel interfaces of the button listener broadcast table.
// blbt_req_if carries input transactions, blbt_notify_if carries notifications.
// Depends on blbt_pkg for field widths.
`default_nettype none

interface blbt_req_if;
    logic                          valid;
    logic                          ready;
    logic [blbt_pkg::CMD_W-1:0]    cmd;
    logic [blbt_pkg::TASK_W-1:0]   task_id;
    logic                          pressed;

    modport source (output valid, output cmd, output task_id, output pressed, input ready);
    modport sink   (input valid, input cmd, input task_id, input pressed, output ready);
endinterface

interface blbt_notify_if;
    logic                          valid;
    logic                          ready;
    logic [blbt_pkg::TASK_W-1:0]   notify_task;
    logic                          last_notify;

    modport source (output valid, output notify_task, output last_notify, input ready);
    modport sink   (input valid, input notify_task, input last_notify, output ready);
endinterface

`default_nettype wire

/* rtl/blbt_front.sv */
// Front end: accepts input transactions, tracks the button level and classifies
// each item into a queued operation or a drop. Depends on blbt_pkg and blbt_if.
`default_nettype none

module blbt_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    blbt_req_if.sink            req,
    output blbt_pkg::op_t       push_data,
    output logic                push_valid,
    input  wire logic           push_ready
);

    logic prev_level_reg;
    logic prev_level_next;
    logic accept;
    logic keep;

    assign req.ready = push_ready;
    assign accept    = req.valid && push_ready;

    always_comb
    begin
        keep              = 1'b0;
        push_data.kind    = blbt_pkg::OP_REGISTER;
        push_data.task_id = req.task_id;
        prev_level_next   = prev_level_reg;
        unique case (blbt_pkg::cmd_t'(req.cmd))
            blbt_pkg::CMD_REGISTER:
            begin
                keep           = 1'b1;
                push_data.kind = blbt_pkg::OP_REGISTER;
            end
            blbt_pkg::CMD_UNREGISTER:
            begin
                keep           = 1'b1;
                push_data.kind = blbt_pkg::OP_UNREGISTER;
            end
            blbt_pkg::CMD_SAMPLE:
            begin
                // Only a rising edge reaches the back end
                keep           = !prev_level_reg && req.pressed;
                push_data.kind = blbt_pkg::OP_PRESS;
                if (accept)
                begin
                    prev_level_next = req.pressed;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_valid = req.valid && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/blbt_queue.sv */
// Short operation queue between front and back end.
// Depth and pointer widths come from blbt_pkg.
`default_nettype none

module blbt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire blbt_pkg::op_t  push_data,
    input  wire logic           push_valid,
    output logic                push_ready,
    output blbt_pkg::op_t       pop_data,
    output logic                pop_valid,
    input  wire logic           pop_ready
);

    localparam int Depth = blbt_pkg::QUEUE_DEPTH;
    localparam int PtrW  = blbt_pkg::QUEUE_PTR_W;
    localparam int CntW  = blbt_pkg::QUEUE_CNT_W;

    blbt_pkg::op_t entry_reg [Depth];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/blbt_back.sv */
// Back end: owns the subscriber table, applies register and unregister
// operations and broadcasts presses one notification per cycle while the sink takes them.
// Depends on blbt_pkg and blbt_if.
`default_nettype none

module blbt_back #(
    parameter int SLOT_COUNT = blbt_pkg::SLOT_COUNT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire blbt_pkg::op_t  pop_data,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    blbt_notify_if.source       notify
);

    localparam int TaskW = blbt_pkg::TASK_W;

    blbt_pkg::back_state_t state_reg;
    blbt_pkg::back_state_t state_next;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic [TaskW-1:0]      task_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] task_wr;
    logic [SLOT_COUNT-1:0] pend_reg;
    logic [SLOT_COUNT-1:0] pend_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [TaskW-1:0]      out_task_reg;
    logic [TaskW-1:0]      out_task_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  take_op;
    logic                  out_free;
    logic [SLOT_COUNT-1:0] hit;
    logic [SLOT_COUNT-1:0] hit_oh;
    logic [SLOT_COUNT-1:0] free_vec;
    logic [SLOT_COUNT-1:0] free_oh;
    logic [SLOT_COUNT-1:0] pick_oh;
    logic [SLOT_COUNT-1:0] rest;
    logic [TaskW-1:0]      pick_task;

    // Outputs of the state machine
    always_comb
    begin
        pop_ready = (state_reg == blbt_pkg::BACK_IDLE);
    end

    assign take_op  = pop_valid && pop_ready;
    assign out_free = !out_valid_reg || notify.ready;

    // Table lookup and lowest-one selects
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit[i] = valid_reg[i] && (task_reg[i] == pop_data.task_id);
        end
        free_vec = ~valid_reg;
        hit_oh   = hit & (~hit + SLOT_COUNT'(1));
        free_oh  = free_vec & (~free_vec + SLOT_COUNT'(1));
        pick_oh  = pend_reg & (~pend_reg + SLOT_COUNT'(1));
        rest     = pend_reg & ~pick_oh;
        pick_task = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pick_oh[i])
            begin
                pick_task = pick_task | task_reg[i];
            end
        end
    end

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        task_wr        = '0;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !notify.ready;
        out_task_next  = out_task_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            blbt_pkg::BACK_IDLE:
            begin
                if (take_op)
                begin
                    unique case (pop_data.kind)
                        blbt_pkg::OP_REGISTER:
                        begin
                            if (hit == '0)
                            begin
                                valid_next = valid_reg | free_oh;
                                task_wr    = free_oh;
                            end
                        end
                        blbt_pkg::OP_UNREGISTER:
                        begin
                            valid_next = valid_reg & ~hit_oh;
                        end
                        blbt_pkg::OP_PRESS:
                        begin
                            // Snapshot listeners; nothing to send if none
                            pend_next = valid_reg;
                            if (valid_reg != '0)
                            begin
                                state_next = blbt_pkg::BACK_BCAST;
                            end
                        end
                        default:
                        begin
                            valid_next = valid_reg;
                        end
                    endcase
                end
            end
            blbt_pkg::BACK_BCAST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_task_next  = pick_task;
                    out_last_next  = (rest == '0);
                    pend_next      = rest;
                    if (rest == '0)
                    begin
                        state_next = blbt_pkg::BACK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = blbt_pkg::BACK_IDLE;
            end
        endcase
    end

    assign notify.valid       = out_valid_reg;
    assign notify.notify_task = out_task_reg;
    assign notify.last_notify = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blbt_pkg::BACK_IDLE;
            valid_reg     <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_task_reg <= out_task_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (task_wr[i])
            begin
                task_reg[i] <= pop_data.task_id;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/button_listener_broadcast_table.sv */
// Top level of the button listener broadcast table: front end, operation
// queue and back end. Depends on blbt_pkg, blbt_if, blbt_front, blbt_queue, blbt_back.
`default_nettype none

// The block keeps SLOT_COUNT subscriber slots, each a task id with a valid
// mark. A register transaction (cmd 0) puts the task into the lowest free slot
// unless it is already present, and is dropped when the table is full. An
// unregister transaction (cmd 1) clears the lowest slot holding the task. A
// sample transaction (cmd 2) records the button level; on a rising edge it
// sends one notification per valid slot in ascending slot order, the final
// one flagged by last_notify, and nothing when no task listens. cmd 3 is
// dropped. The front end takes one transaction per cycle while the two-entry
// operation queue has room; sample transactions without a rising edge and
// cmd 3 never enter the queue. The back end applies a register or unregister
// operation on taking it; a press sends one notification per listener, and no
// further operation is taken until the last one is issued; the single
// notification output register paces the broadcast and holds each
// notification until the sink takes it. Operations take effect strictly in
// arrival order, so a press sees every registration accepted before it.
module button_listener_broadcast_table #(
    parameter int SLOT_COUNT = blbt_pkg::SLOT_COUNT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    blbt_req_if.sink        req,
    blbt_notify_if.source   notify
);

    blbt_pkg::op_t push_data;
    logic          push_valid;
    logic          push_ready;
    blbt_pkg::op_t pop_data;
    logic          pop_valid;
    logic          pop_ready;

    // Classify transactions and track the button level
    blbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Decouple classification from table work and broadcast
    blbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Apply table updates and send notifications
    blbt_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .notify     (notify)
    );

endmodule

`default_nettype wire

/* tb/sv/button_listener_broadcast_table_tb.sv */
// Self-checking testbench for the button listener broadcast table.
// Depends on blbt_pkg, blbt_if and the button_listener_broadcast_table RTL.
`timescale 1ns / 100ps

module button_listener_broadcast_table_tb;
    import blbt_pkg::*;

    localparam int RANDOM_ITEMS   = 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 2 * SLOT_COUNT + 24;
    localparam int ID_POOL_SIZE   = 12;

    // One notification as the sink should see it.
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic              last_notify;
    } notice_t;

    // Mirror of the subscriber table and the button level. Every accepted
    // request transaction is folded in here, and presses queue the
    // notifications they must produce.
    class subscriber_tracker;
        bit [TASK_W-1:0] slot_task [SLOT_COUNT];
        bit              slot_used [SLOT_COUNT];
        bit              level_q;
        notice_t         awaited_notices [$];
        int              error_count;

        function void record_request(cmd_t cmd, logic [TASK_W-1:0] id, logic lvl);
            int hit;
            int free_idx;
            int last_idx;
            hit      = -1;
            free_idx = -1;
            last_idx = -1;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (slot_used[i] && slot_task[i] == id && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_idx < 0)
                    free_idx = i;
                if (slot_used[i])
                    last_idx = i;
            end
            case (cmd)
                CMD_REGISTER:
                begin
                    if (hit < 0 && free_idx >= 0)
                    begin
                        slot_used[free_idx] = 1'b1;
                        slot_task[free_idx] = id;
                    end
                end
                CMD_UNREGISTER:
                begin
                    if (hit >= 0)
                    begin
                        slot_used[hit] = 1'b0;
                        slot_task[hit] = '0;
                    end
                end
                CMD_SAMPLE:
                begin
                    if (!level_q && lvl)
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (slot_used[i])
                                awaited_notices.push_back({slot_task[i], 1'(i == last_idx)});
                        end
                    end
                    level_q = lvl;
                end
                default: ;
            endcase
        endfunction

        function void check_notification(logic [TASK_W-1:0] got_task, logic got_last);
            notice_t want;
            if (awaited_notices.size() == 0)
            begin
                $error("unexpected notification: notify_task=%0h last_notify=%0b",
                       got_task, got_last);
                error_count++;
                return;
            end
            want = awaited_notices.pop_front();
            if (got_task !== want.task_id)
            begin
                $error("notify_task: expected %0h, got %0h", want.task_id, got_task);
                error_count++;
            end
            if (got_last !== want.last_notify)
            begin
                $error("last_notify: expected %0b, got %0b", want.last_notify, got_last);
                error_count++;
            end
        endfunction

        function int pending();
            return awaited_notices.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    blbt_req_if    req_ch ();
    blbt_notify_if notify_ch ();

    button_listener_broadcast_table DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .notify (notify_ch)
    );

    subscriber_tracker tracker;
    logic [TASK_W-1:0] id_pool [ID_POOL_SIZE];
    int                sink_mode;
    int                sink_left;
    int                sink_phase;
    int                quiet_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Present one request transaction at the falling edge and hold it until
    // the block takes it. Back-to-back calls keep valid high throughout.
    task automatic send_request(input cmd_t cmd, input logic [TASK_W-1:0] id,
                                input logic lvl);
        @(negedge clk);
        req_ch.valid   = 1'b1;
        req_ch.cmd     = cmd;
        req_ch.task_id = id;
        req_ch.pressed = lvl;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.record_request(cmd, id, lvl);
    endtask

    // Drop valid for a number of cycles, with junk on the payload lines.
    task automatic hold_idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid   = 1'b0;
            req_ch.cmd     = cmd_t'($urandom_range(0, 3));
            req_ch.task_id = TASK_W'($urandom_range(0, 255));
            req_ch.pressed = 1'($urandom_range(0, 1));
        end
    endtask

    // Drop valid and wait until every queued notification has come back.
    task automatic drain_notices();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TASK_W-1:0] pick_id();
        // Mostly reuse a small pool so duplicates and unregister hits happen.
        if ($urandom_range(0, 9) < 7)
            return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        return TASK_W'($urandom_range(0, 255));
    endfunction

    // Notification sink: stall on a pattern whose mode changes at random
    // intervals - always ready, coin flip, mostly stalled, square wave.
    initial
    begin
        notify_ch.ready = 1'b0;
        sink_left       = 0;
        sink_phase      = 0;
        forever
        begin
            @(negedge clk);
            if (sink_left == 0)
            begin
                sink_mode = $urandom_range(0, 3);
                sink_left = $urandom_range(20, 80);
            end
            sink_left--;
            sink_phase++;
            case (sink_mode)
                0:       notify_ch.ready = 1'b1;
                1:       notify_ch.ready = 1'($urandom_range(0, 1));
                2:       notify_ch.ready = ($urandom_range(0, 3) == 0);
                default: notify_ch.ready = sink_phase[2];
            endcase
        end
    end

    // Check every notification the sink takes against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && notify_ch.valid && notify_ch.ready)
            tracker.check_notification(notify_ch.notify_task, notify_ch.last_notify);
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (notify_ch.valid && notify_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("button_listener_broadcast_table regression: fail");
            $finish;
        end
    end

    initial
    begin
        int          counted;
        int          burst_len;
        int          pick;
        cmd_t        cmd;
        logic [TASK_W-1:0] id;
        logic        lvl;

        tracker        = new;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_IGNORE;
        req_ch.task_id = '0;
        req_ch.pressed = 1'b0;

        id_pool[0] = 8'h00;
        id_pool[1] = 8'hFF;
        for (int i = 2; i < ID_POOL_SIZE; i++)
            id_pool[i] = TASK_W'($urandom_range(0, 255));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Samples with no listener: low level, then a rising
        // edge that must emit nothing but still records the level.
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b0);
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b1);
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b0);

        // Fill the table with extreme and mixed ids; repeat one registration.
        send_request(CMD_REGISTER, 8'h00, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'hFF, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'hFF, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'hA5, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'h3C, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'hC3, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'h01, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'h80, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'h7E, 1'($urandom_range(0, 1)));
        // Table is full now: this one must be dropped.
        send_request(CMD_REGISTER, 8'h42, 1'($urandom_range(0, 1)));

        // Full broadcast, then a held level (no edge) and a release.
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b1);
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b1);
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b0);

        // Unknown unregister, free slot 0 and refill it, ignored command.
        send_request(CMD_UNREGISTER, 8'h99, 1'($urandom_range(0, 1)));
        send_request(CMD_UNREGISTER, 8'h00, 1'($urandom_range(0, 1)));
        send_request(CMD_REGISTER, 8'h5A, 1'($urandom_range(0, 1)));
        send_request(CMD_IGNORE, TASK_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_request(CMD_UNREGISTER, 8'hFF, 1'($urandom_range(0, 1)));
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b1);
        send_request(CMD_SAMPLE, TASK_W'($urandom_range(0, 255)), 1'b0);

        // Hold off until the directed broadcasts are all back.
        drain_notices();

        // Random part: bursts of mixed traffic with random gaps. Samples
        // mostly toggle the level so rising edges are common.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 12);
            repeat (burst_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    cmd = CMD_REGISTER;
                else if (pick < 60)
                    cmd = CMD_UNREGISTER;
                else if (pick < 95)
                    cmd = CMD_SAMPLE;
                else
                    cmd = CMD_IGNORE;
                id  = pick_id();
                lvl = 1'($urandom_range(0, 1));
                if (cmd == CMD_SAMPLE && $urandom_range(0, 9) < 7)
                    lvl = !tracker.level_q;
                send_request(cmd, id, lvl);
                if (cmd != CMD_IGNORE)
                    counted++;
            end
            if ($urandom_range(0, 9) == 0)
                drain_notices();
            else
                hold_idle($urandom_range(0, 8));
        end

        // Wind down: wait for every expected notification, then give the
        // block time to show any extra one.
        hold_idle(1);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.error_count == 0 && tracker.pending() == 0)
            $display("button_listener_broadcast_table regression: pass");
        else
            $display("button_listener_broadcast_table regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/blbt_pkg.sv
rtl/blbt_if.sv
rtl/blbt_front.sv
rtl/blbt_queue.sv
rtl/blbt_back.sv
rtl/button_listener_broadcast_table.sv
tb/sv/button_listener_broadcast_table_tb.sv
